>>> sv/iwc_pkg.sv
// Package for the IP ingress writable classifier.
// Holds the per-packet state type, the reason codes, protocol numbers and the
// IPv6 next-header judgment. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iwc_pkg;

	localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;
	localparam logic [3:0]  MAX_EXT_DEPTH    = 4'd8;
	localparam logic [15:0] IPV4_MIN_LEN     = 16'd20;
	localparam logic [15:0] IPV6_FIXED_LEN   = 16'd40;

	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;

	localparam logic [7:0] PROTO_HOPOPTS  = 8'd0;
	localparam logic [7:0] PROTO_ICMP     = 8'd1;
	localparam logic [7:0] PROTO_ROUTING  = 8'd43;
	localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
	localparam logic [7:0] PROTO_ICMPV6   = 8'd58;
	localparam logic [7:0] PROTO_DESTOPTS = 8'd60;

	// Byte offsets inside the fixed headers.
	localparam logic [15:0] OFS_FLAGS_HI = 16'd6;
	localparam logic [15:0] OFS_FLAGS_LO = 16'd7;
	localparam logic [15:0] OFS_V4_PROTO = 16'd9;
	localparam logic [15:0] OFS_V6_NH    = 16'd6;

	typedef enum logic [2:0] {
		RSN_READONLY = 3'd0,
		RSN_SHORT    = 3'd1,
		RSN_VERSION  = 3'd2,
		RSN_ICMP     = 3'd3,
		RSN_FRAG     = 3'd4,
		RSN_TRUNC    = 3'd5,
		RSN_DEEP     = 3'd6
	} reason_t;

	typedef struct packed {
		logic    known;
		logic    value;
		reason_t reason;
	} verdict_t;

	typedef struct packed {
		logic [15:0] pos;      // bytes seen, saturating
		logic [3:0]  ver;
		logic [7:0]  flags_hi;
		logic [7:0]  nh;
		logic [15:0] ext_off;  // offset of the pending extension header
		logic [3:0]  depth;
		verdict_t    verdict;
	} pkt_state_t;

	localparam pkt_state_t STATE_CLEAR = '{
		pos:      16'd0,
		ver:      4'd0,
		flags_hi: 8'd0,
		nh:       8'd0,
		ext_off:  IPV6_FIXED_LEN,
		depth:    4'd0,
		verdict:  '{known: 1'b0, value: 1'b0, reason: RSN_READONLY}
	};

	// Judge an IPv6 next-header value at a given chain depth. The known bit
	// stays low for the walkable extension headers below the depth limit.
	function automatic verdict_t judge_v6(input logic [3:0] depth, input logic [7:0] nh);
		verdict_t v;
		v = '{known: 1'b1, value: 1'b0, reason: RSN_READONLY};
		if (depth >= MAX_EXT_DEPTH) begin
			v.value  = 1'b1;
			v.reason = RSN_DEEP;
		end else if (nh == PROTO_ICMPV6) begin
			v.value  = 1'b1;
			v.reason = RSN_ICMP;
		end else if (nh == PROTO_FRAGMENT) begin
			v.value  = 1'b1;
			v.reason = RSN_FRAG;
		end else if (nh == PROTO_HOPOPTS || nh == PROTO_ROUTING || nh == PROTO_DESTOPTS) begin
			v.known = 1'b0;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

>>> sv/ip_ingress_writable_classifier_top.sv
// Top level of the IP ingress writable classifier.
// Depends on iwc_pkg and iwc_byte_step.
`timescale 1ns / 1ps
`default_nettype none

// The block takes an IP packet one byte per request on the slave stream, with
// tlast on the final byte, and returns one verdict request on the master
// stream for each packet: whether the packet must take the writable copy path,
// and why. IPv4 ICMP and IPv4 fragments, IPv6 ICMPv6, fragment headers,
// truncated or overly deep extension chains, short packets and unknown
// versions all need writable storage; any other packet is read-only. Each
// byte goes through an input register, then combinational header parsing
// against the per-packet state, and the verdict lands in an output register.
// The block takes one byte every cycle unless a final byte waits in the input
// register; a byte is parsed in the cycle after the edge that accepts it, and
// the verdict of a final byte goes into the output register once that is free.
// Only a final byte waits on a full output register; other bytes pass even
// while a verdict is stalled. Bytes at position 65535 and beyond in a packet
// are ignored. Per-packet state clears after every final byte and at reset.
module ip_ingress_writable_classifier_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] pkt_byte
	input  wire logic       s_axis_tlast,   // last_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // [0] needs_writable, [3:1] reason, [7:4] zero
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Per-packet parse state.
	iwc_pkg::pkt_state_t state_q;
	iwc_pkg::pkt_state_t state_nxt;

	// Result register.
	logic             out_valid_q;
	logic             need_q;
	iwc_pkg::reason_t reason_q;

	logic             need_c;
	iwc_pkg::reason_t reason_c;
	logic             out_free;
	logic             proc;

	iwc_byte_step u_step (
		.cur            (state_q),
		.pkt_byte       (byte_s1),
		.nxt            (state_nxt),
		.needs_writable (need_c),
		.reason         (reason_c)
	);

	// A byte in the input stage is parsed unless it ends a packet and the
	// previous verdict has not been taken yet.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iwc_pkg::STATE_CLEAR;
		end else if (proc) begin
			state_q <= last_s1 ? iwc_pkg::STATE_CLEAR : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			need_q   <= need_c;
			reason_q <= reason_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, reason_q, need_q};

endmodule

`default_nettype wire

>>> sv/iwc_byte_step.sv
// Per-byte header parser of the IP ingress writable classifier.
// Combinational: takes the packet state and one byte, gives the next state
// and the verdict that applies if this byte ends the packet. Uses iwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iwc_byte_step (
	input  wire iwc_pkg::pkt_state_t cur,
	input  wire logic [7:0]          pkt_byte,
	output iwc_pkg::pkt_state_t      nxt,
	output logic                     needs_writable,
	output iwc_pkg::reason_t         reason
);

	iwc_pkg::verdict_t jv;
	logic              frag;
	logic [16:0]       off_plus1;
	logic [8:0]        len_units;
	logic [3:0]        depth_inc;
	logic              in_ext;

	assign off_plus1 = {1'b0, cur.ext_off} + 17'd1;
	assign len_units = {1'b0, pkt_byte} + 9'd1;
	assign depth_inc = cur.depth + 4'd1;
	assign frag      = cur.flags_hi[5] | (cur.flags_hi[4:0] != 5'd0) | (pkt_byte != 8'd0);
	assign in_ext    = (cur.pos >= iwc_pkg::IPV6_FIXED_LEN);

	always_comb begin
		nxt = cur;
		jv  = '{known: 1'b0, value: 1'b0, reason: iwc_pkg::RSN_READONLY};
		if (cur.pos < iwc_pkg::MAX_PACKET_BYTES) begin
			nxt.pos = cur.pos + 16'd1;
			if (cur.pos == 16'd0) begin
				nxt.ver = pkt_byte[7:4];
			end else if (cur.ver == iwc_pkg::VER_IPV4) begin
				if (cur.pos == iwc_pkg::OFS_FLAGS_HI) begin
					nxt.flags_hi = pkt_byte;
				end else if (cur.pos == iwc_pkg::OFS_FLAGS_LO) begin
					nxt.verdict = '{known: 1'b1, value: frag,
						reason: frag ? iwc_pkg::RSN_FRAG : iwc_pkg::RSN_READONLY};
				end else if (cur.pos == iwc_pkg::OFS_V4_PROTO
						&& pkt_byte == iwc_pkg::PROTO_ICMP) begin
					nxt.verdict = '{known: 1'b1, value: 1'b1, reason: iwc_pkg::RSN_ICMP};
				end
			end else if (cur.ver == iwc_pkg::VER_IPV6 && !cur.verdict.known) begin
				if (cur.pos == iwc_pkg::OFS_V6_NH) begin
					nxt.nh = pkt_byte;
					jv     = iwc_pkg::judge_v6(cur.depth, pkt_byte);
					if (jv.known) begin
						nxt.verdict = jv;
					end
				end else if (in_ext && cur.pos == cur.ext_off) begin
					nxt.nh = pkt_byte;
				end else if (in_ext && {1'b0, cur.pos} == off_plus1) begin
					// Header length is in 8-byte units, not counting the first.
					nxt.ext_off = cur.ext_off + {4'd0, len_units, 3'd0};
					nxt.depth   = depth_inc;
					jv          = iwc_pkg::judge_v6(depth_inc, cur.nh);
					if (jv.known) begin
						nxt.verdict = jv;
					end
				end
			end
		end
	end

	always_comb begin
		if (nxt.pos < iwc_pkg::IPV4_MIN_LEN) begin
			needs_writable = 1'b1;
			reason         = iwc_pkg::RSN_SHORT;
		end else if (nxt.ver == iwc_pkg::VER_IPV4) begin
			needs_writable = nxt.verdict.value;
			reason         = nxt.verdict.reason;
		end else if (nxt.ver == iwc_pkg::VER_IPV6) begin
			if (nxt.pos < iwc_pkg::IPV6_FIXED_LEN) begin
				needs_writable = 1'b1;
				reason         = iwc_pkg::RSN_SHORT;
			end else if (nxt.verdict.known) begin
				needs_writable = nxt.verdict.value;
				reason         = nxt.verdict.reason;
			end else begin
				needs_writable = 1'b1;
				reason         = iwc_pkg::RSN_TRUNC;
			end
		end else begin
			needs_writable = 1'b1;
			reason         = iwc_pkg::RSN_VERSION;
		end
	end

endmodule

`default_nettype wire
